// ----- design/current_sensor_power_detector_top_defines.svh -----
// Assertion macros for the current sensor power detector.
`ifndef CURRENT_SENSOR_POWER_DETECTOR_TOP_DEFINES_SVH
`define CURRENT_SENSOR_POWER_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CSPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSPD_ASSERT(lbl, prop, msg)
`define CSPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/cspd_pkg.sv -----
// Shared types, codes and constants of the current sensor power detector.
package cspd_pkg;

	localparam int SAMPLES_PER_CYCLE = 8;
	localparam int CALIB_CYCLES      = 8;

	localparam int SAMPLE_W   = 14;
	localparam int BASE_W     = 20;
	localparam int DIFF_W     = BASE_W + 2;
	localparam int SCALE_W    = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0] MIN_RESET      = 14'd16383;
	localparam logic [SAMPLE_W-1:0] ZERO_REF_RESET = 14'd10750;

	localparam logic [CFG_ADDR_W-1:0] REG_LOAD_MARGIN    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_COUNT    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WAIT_CYCLES    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CHECK_CYCLES   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_SCALE    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ZERO_REFERENCE = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_OVERCURRENT    = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL      = 3'd7;

	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_CALIB_DONE = 3'd1;
	localparam logic [2:0] EV_CHECK_FAIL = 3'd2;
	localparam logic [2:0] EV_WAIT_OK    = 3'd3;
	localparam logic [2:0] EV_CHECK_OK   = 3'd4;
	localparam logic [2:0] EV_POWER_ON   = 3'd5;
	localparam logic [2:0] EV_POWER_OFF  = 3'd6;
	localparam logic [2:0] EV_LEVEL_CHG  = 3'd7;

	localparam logic [1:0] TP_KEEP        = 2'd0;
	localparam logic [1:0] TP_MINOR       = 2'd1;
	localparam logic [1:0] TP_MAJOR       = 2'd2;
	localparam logic [1:0] TP_SHORT_MAJOR = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] load_margin;
		logic [7:0]          limit_count;
		logic [7:0]          wait_cycles;
		logic [7:0]          check_cycles;
		logic [SCALE_W-1:0]  level_scale;
		logic [SAMPLE_W-1:0] zero_reference;
		logic [6:0]          overcurrent_level;
		logic [6:0]          max_level;
	} cfg_t;

	typedef struct packed {
		logic                cycle_done;
		logic [2:0]          event_res;
		logic [1:0]          timer_period;
		logic [SAMPLE_W-1:0] cycle_minimum;
		logic signed [7:0]   current_level;
		logic signed [7:0]   reported_level;
		logic                over_current;
	} res_t;

endpackage

// ----- design/current_sensor_power_detector_top.sv -----
// Current sensor power detector top level: request pipeline around the detector core.
//
// Input channel (in_valid/in_ready) carries one request: kind 0 is a 14-bit ADC
// sample, kind 1 starts a calibration. Every request yields exactly one result on
// the output channel (out_valid/out_ready).
// A request is held in an input register; when it advances, the core updates its
// state and the result is captured in the output register, which drives out_valid.
// One request per cycle is sustained while the receiver takes every result; the
// rate is set by the state update between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register still takes one more request; in_ready drops only when both are full.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at the next
// edge and are meant for when no request is in flight.
// Reset (arst_n low) empties both registers, returns the detector to the
// uncalibrated state and loads the register defaults.
`include "current_sensor_power_detector_top_defines.svh"

module current_sensor_power_detector_top #(
	parameter int SAMPLES_PER_CYCLE = cspd_pkg::SAMPLES_PER_CYCLE,
	parameter int CALIB_CYCLES      = cspd_pkg::CALIB_CYCLES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cspd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [cspd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [cspd_pkg::SAMPLE_W-1:0]     sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              cycle_done,
	output logic [2:0]                        event_res,
	output logic [1:0]                        timer_period,
	output logic [cspd_pkg::SAMPLE_W-1:0]     cycle_minimum,
	output logic signed [7:0]                 current_level,
	output logic signed [7:0]                 reported_level,
	output logic                              over_current
);

	cspd_pkg::cfg_t cfg;
	cspd_pkg::res_t res;
	cspd_pkg::res_t res_s2;

	logic                          valid_s1, valid_s2;
	logic                          kind_s1;
	logic [cspd_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	cspd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cspd_core #(
		.SAMPLES_PER_CYCLE (SAMPLES_PER_CYCLE),
		.CALIB_CYCLES      (CALIB_CYCLES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.go     (advance),
		.kind   (kind_s1),
		.sample (sample_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1   <= kind;
			sample_s1 <= sample;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign cycle_done     = res_s2.cycle_done;
	assign event_res      = res_s2.event_res;
	assign timer_period   = res_s2.timer_period;
	assign cycle_minimum  = res_s2.cycle_minimum;
	assign current_level  = res_s2.current_level;
	assign reported_level = res_s2.reported_level;
	assign over_current   = res_s2.over_current;

	`CSPD_ASSERT(a_ready_when_out_empty, !valid_s2 |-> in_ready, "input stalled with empty output")
	`CSPD_ASSERT(a_done_period, (valid_s2 && res_s2.cycle_done) |-> (res_s2.timer_period == cspd_pkg::TP_MAJOR || res_s2.timer_period == cspd_pkg::TP_SHORT_MAJOR), "cycle end without major period")
	`CSPD_ASSERT(a_event_on_done, (valid_s2 && res_s2.event_res != cspd_pkg::EV_NONE) |-> res_s2.cycle_done, "event outside a cycle end")
	`CSPD_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!valid_s1 && !valid_s2), "pipeline not empty after reset")

endmodule

// ----- design/cspd_cfg.sv -----
// Configuration register file.
module cspd_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [cspd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [cspd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output cspd_pkg::cfg_t                       cfg
);

	cspd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.load_margin       <= '0;
			cfg_q.limit_count       <= '0;
			cfg_q.wait_cycles       <= 8'd1;
			cfg_q.check_cycles      <= 8'd1;
			cfg_q.level_scale       <= '0;
			cfg_q.zero_reference    <= cspd_pkg::ZERO_REF_RESET;
			cfg_q.overcurrent_level <= 7'd127;
			cfg_q.max_level         <= 7'd127;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				cspd_pkg::REG_LOAD_MARGIN:    cfg_q.load_margin <= cfg_wdata[13:0];
				cspd_pkg::REG_LIMIT_COUNT:    cfg_q.limit_count <= cfg_wdata[7:0];
				cspd_pkg::REG_WAIT_CYCLES:    cfg_q.wait_cycles <= cfg_wdata[7:0];
				cspd_pkg::REG_CHECK_CYCLES:   cfg_q.check_cycles <= cfg_wdata[7:0];
				cspd_pkg::REG_LEVEL_SCALE:    cfg_q.level_scale <= cfg_wdata;
				cspd_pkg::REG_ZERO_REFERENCE: cfg_q.zero_reference <= cfg_wdata[13:0];
				cspd_pkg::REG_OVERCURRENT:    cfg_q.overcurrent_level <= cfg_wdata[6:0];
				cspd_pkg::REG_MAX_LEVEL:      cfg_q.max_level <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/cspd_scale.sv -----
// Q0.16 scaling of a sample difference, truncated toward zero, saturated to int8.
module cspd_scale (
	input  logic signed [cspd_pkg::DIFF_W-1:0]  diff,
	input  logic [cspd_pkg::SCALE_W-1:0]        scale,
	output logic signed [7:0]                   level
);

	localparam int DW = cspd_pkg::DIFF_W;
	localparam int SW = cspd_pkg::SCALE_W;

	logic [DW-1:0]    mag;
	logic [DW+SW-1:0] prod;
	logic [DW-1:0]    q;
	logic [7:0]       q_neg;

	assign mag   = diff[DW-1] ? DW'(-diff) : diff;
	assign prod  = {{SW{1'b0}}, mag} * {{DW{1'b0}}, scale};
	assign q     = prod[DW+SW-1:SW];
	assign q_neg = ~q[7:0] + 8'd1;

	always_comb begin
		if (diff[DW-1]) begin
			level = (q > DW'(128)) ? -8'sd128 : $signed(q_neg);
		end else begin
			level = (q > DW'(127)) ? 8'sd127 : $signed(q[7:0]);
		end
	end

endmodule

// ----- design/cspd_core.sv -----
// Detector state: cycle tracking, calibration, wait/check sequences, hysteresis.
module cspd_core #(
	parameter int SAMPLES_PER_CYCLE = cspd_pkg::SAMPLES_PER_CYCLE,
	parameter int CALIB_CYCLES      = cspd_pkg::CALIB_CYCLES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cspd_pkg::cfg_t                    cfg,
	input  logic                              go,
	input  logic                              kind,
	input  logic [cspd_pkg::SAMPLE_W-1:0]     sample,
	output cspd_pkg::res_t                    res
);

	localparam int SW     = cspd_pkg::SAMPLE_W;
	localparam int BW     = cspd_pkg::BASE_W;
	localparam int DW     = cspd_pkg::DIFF_W;
	localparam int IDX_W  = (SAMPLES_PER_CYCLE > 1) ? $clog2(SAMPLES_PER_CYCLE) : 1;
	localparam int CR_W   = $clog2(CALIB_CYCLES + 1);
	localparam int DIV_SH = BW + $clog2(CALIB_CYCLES);
	localparam int MUL_W  = BW + 1;
	localparam longint DIV_M = ((64'sd1 <<< DIV_SH) + CALIB_CYCLES - 1) / CALIB_CYCLES;
	localparam logic [MUL_W-1:0] DIV_MULT = MUL_W'(DIV_M);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_CYCLE - 1);

	typedef enum logic [1:0] {PH_NEVER, PH_RUN, PH_DONE} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [CR_W-1:0]    calib_rem;
		logic [BW-1:0]      baseline;
		logic [7:0]         wait_rem;
		logic [7:0]         check_rem;
		logic               check_ok;
		logic [IDX_W-1:0]   idx;
		logic [7:0]         below;
		logic [SW-1:0]      run_min;
		logic [SW-1:0]      last_min;
		logic signed [7:0]  level_now;
		logic signed [7:0]  level_before;
		logic signed [7:0]  abs_level;
		logic               power_on;
		logic               short_period;
	} state_t;

	state_t state_q, state_d;

	logic [SW-1:0]          min_upd;
	logic [7:0]             below_upd;
	logic                   is_below;
	logic signed [DW-1:0]   diff_base, diff_zero;
	logic signed [7:0]      lvl_base, lvl_zero;
	logic [BW+MUL_W-1:0]    div_prod;
	logic [BW-1:0]          base_avg;
	logic signed [8:0]      lvl_delta;
	logic [7:0]             wait_dec, check_dec;
	logic                   chk_ok_new;
	logic signed [8:0]      rep_sum;
	logic [2:0]             ev;
	logic [1:0]             period;
	logic                   done;

	assign min_upd   = (sample < state_q.run_min) ? sample : state_q.run_min;
	assign is_below  = ({7'd0, sample} + {7'd0, cfg.load_margin}) < {1'b0, state_q.baseline};
	assign below_upd = state_q.below + {7'd0, is_below};

	assign diff_base = $signed({2'b00, state_q.baseline}) - $signed({{(DW-SW){1'b0}}, min_upd});
	assign diff_zero = $signed({{(DW-SW){1'b0}}, cfg.zero_reference})
	                 - $signed({{(DW-SW){1'b0}}, min_upd});

	cspd_scale u_scale_base (
		.diff  (diff_base),
		.scale (cfg.level_scale),
		.level (lvl_base)
	);

	cspd_scale u_scale_zero (
		.diff  (diff_zero),
		.scale (cfg.level_scale),
		.level (lvl_zero)
	);

	assign div_prod  = {{MUL_W{1'b0}}, state_q.baseline} * {{BW{1'b0}}, DIV_MULT};
	assign base_avg  = BW'(div_prod >> DIV_SH);
	assign lvl_delta = $signed({lvl_base[7], lvl_base})
	                 - $signed({state_q.level_now[7], state_q.level_now});
	assign wait_dec  = state_q.wait_rem - 8'd1;
	assign check_dec = state_q.check_rem - 8'd1;
	assign chk_ok_new = state_q.check_ok && (below_upd > cfg.limit_count);

	always_comb begin
		state_d = state_q;
		ev      = cspd_pkg::EV_NONE;
		period  = cspd_pkg::TP_KEEP;
		done    = 1'b0;
		if (kind) begin
			state_d.wait_rem     = '0;
			state_d.check_rem    = '0;
			state_d.check_ok     = 1'b0;
			state_d.calib_rem    = CR_W'(CALIB_CYCLES);
			state_d.baseline     = '0;
			state_d.run_min      = cspd_pkg::MIN_RESET;
			state_d.idx          = '0;
			state_d.below        = '0;
			state_d.phase        = PH_RUN;
			state_d.short_period = 1'b0;
		end else if (state_q.idx != IDX_LAST) begin
			if (state_q.idx == '0) begin
				period = cspd_pkg::TP_MINOR;
			end
			state_d.idx     = state_q.idx + IDX_W'(1);
			state_d.run_min = min_upd;
			state_d.below   = below_upd;
		end else begin
			done = 1'b1;
			period = state_q.short_period ? cspd_pkg::TP_SHORT_MAJOR : cspd_pkg::TP_MAJOR;
			state_d.last_min     = min_upd;
			state_d.level_before = state_q.level_now;
			state_d.level_now    = lvl_base;
			state_d.abs_level    = lvl_zero;
			state_d.run_min      = cspd_pkg::MIN_RESET;
			state_d.idx          = '0;
			state_d.below        = '0;
			if (state_q.phase == PH_RUN) begin
				if (state_q.calib_rem == '0) begin
					state_d.phase    = PH_DONE;
					state_d.baseline = base_avg;
					state_d.wait_rem = (cfg.wait_cycles == 8'd0) ? 8'd1 : cfg.wait_cycles;
					ev = cspd_pkg::EV_CALIB_DONE;
				end else begin
					state_d.calib_rem = state_q.calib_rem - CR_W'(1);
					state_d.baseline  = state_q.baseline + {{(BW-SW){1'b0}}, min_upd};
				end
			end else if (state_q.wait_rem != 8'd0) begin
				state_d.wait_rem = wait_dec;
				if (wait_dec == 8'd0) begin
					state_d.phase = PH_NEVER;
					ev = cspd_pkg::EV_CHECK_FAIL;
				end else if (below_upd > cfg.limit_count) begin
					state_d.check_rem = (cfg.check_cycles == 8'd0) ? 8'd1 : cfg.check_cycles;
					state_d.wait_rem  = '0;
					state_d.check_ok  = 1'b1;
					state_d.short_period = 1'b1;
					ev = cspd_pkg::EV_WAIT_OK;
				end
			end else if (state_q.check_rem != 8'd0) begin
				state_d.check_rem = check_dec;
				state_d.check_ok  = chk_ok_new;
				if (check_dec == 8'd0) begin
					state_d.short_period = 1'b0;
					if (chk_ok_new) begin
						ev = cspd_pkg::EV_CHECK_OK;
					end else begin
						state_d.phase = PH_NEVER;
						ev = cspd_pkg::EV_CHECK_FAIL;
					end
				end
			end else if ((below_upd > cfg.limit_count) && !state_q.power_on) begin
				state_d.power_on = 1'b1;
				ev = cspd_pkg::EV_POWER_ON;
			end else if (state_q.power_on) begin
				if (below_upd < cfg.limit_count) begin
					state_d.power_on = 1'b0;
					ev = cspd_pkg::EV_POWER_OFF;
				end else if ((lvl_delta >= 9'sd2) || (lvl_delta <= -9'sd2)) begin
					ev = cspd_pkg::EV_LEVEL_CHG;
				end
			end
		end
	end

	assign rep_sum = $signed({state_d.level_now[7], state_d.level_now})
	               + $signed({8'd0, state_d.power_on});

	always_comb begin
		res.cycle_done    = done;
		res.event_res     = ev;
		res.timer_period  = period;
		res.cycle_minimum = state_d.last_min;
		res.current_level = state_d.level_now;
		if (rep_sum > $signed({2'b00, cfg.max_level})) begin
			res.reported_level = $signed({1'b0, cfg.max_level});
		end else begin
			res.reported_level = rep_sum[7:0];
		end
		res.over_current = (state_d.abs_level >= $signed({1'b0, cfg.overcurrent_level}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_NEVER;
			state_q.calib_rem    <= '0;
			state_q.baseline     <= '0;
			state_q.wait_rem     <= '0;
			state_q.check_rem    <= '0;
			state_q.check_ok     <= 1'b0;
			state_q.idx          <= '0;
			state_q.below        <= '0;
			state_q.run_min      <= cspd_pkg::MIN_RESET;
			state_q.last_min     <= cspd_pkg::MIN_RESET;
			state_q.level_now    <= '0;
			state_q.level_before <= '0;
			state_q.abs_level    <= '0;
			state_q.power_on     <= 1'b0;
			state_q.short_period <= 1'b0;
		end else if (go) begin
			state_q <= state_d;
		end
	end

endmodule

// ----- dv/tb_current_sensor_power_detector_top.sv -----
// Self-checking testbench for the current sensor power detector: random sessions against a local predictor.
module tb_current_sensor_power_detector_top;

	localparam int ITEM_TARGET = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SW          = cspd_pkg::SAMPLE_W;
	localparam int BW          = cspd_pkg::BASE_W;
	localparam int CFG_AW      = cspd_pkg::CFG_ADDR_W;
	localparam int CFG_DW      = cspd_pkg::CFG_DATA_W;
	localparam int SPC         = cspd_pkg::SAMPLES_PER_CYCLE;
	localparam int NCAL        = cspd_pkg::CALIB_CYCLES;

	typedef enum logic [1:0] {CAL_NONE, CAL_RUNNING, CAL_DONE} calib_state_t;

	typedef struct packed {
		logic          kind;
		logic [SW-1:0] sample;
	} req_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = cspd_pkg::REG_LOAD_MARGIN;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              kind = 1'b0;
	logic [SW-1:0]     sample = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              cycle_done;
	logic [2:0]        event_res;
	logic [1:0]        timer_period;
	logic [SW-1:0]     cycle_minimum;
	logic signed [7:0] current_level;
	logic signed [7:0] reported_level;
	logic              over_current;

	// predictor copy of the detector
	cspd_pkg::cfg_t    cfg_shadow;
	calib_state_t      calib_state;
	logic [7:0]        calib_left;
	logic [BW-1:0]     base_acc;
	logic [7:0]        wait_left;
	logic [7:0]        check_left;
	logic              check_pass;
	logic [7:0]        slot;
	logic [7:0]        loaded;
	logic [SW-1:0]     run_min;
	logic [SW-1:0]     last_min;
	logic signed [7:0] lvl_now;
	logic signed [7:0] lvl_prev;
	logic signed [7:0] abs_lvl;
	logic              powered;
	logic              short_mode;

	req_t              pend_q[$];
	cspd_pkg::res_t    exp_q[$];
	cspd_pkg::res_t    want;
	req_t              nxt;
	int                queued = 0;
	int                fail_count = 0;
	int                gap_left = 0;
	int                stall_left = 0;
	int                cycle_count = 0;
	bit                in_fast = 1'b0;
	bit                out_fast = 1'b0;

	current_sensor_power_detector_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cycle_done    (cycle_done),
		.event_res     (event_res),
		.timer_period  (timer_period),
		.cycle_minimum (cycle_minimum),
		.current_level (current_level),
		.reported_level(reported_level),
		.over_current  (over_current)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic signed [7:0] scaled_level(input longint diff);
		longint mag;
		longint q;
		mag = (diff < 0) ? -diff : diff;
		q = (mag * longint'(cfg_shadow.level_scale)) >>> 16;
		if (diff < 0)
			return (q > 128) ? 8'h80 : 8'(-q);
		return (q > 127) ? 8'h7f : 8'(q);
	endfunction

	function automatic cspd_pkg::res_t detector_step(input logic k, input logic [SW-1:0] s);
		cspd_pkg::res_t r;
		logic cycle_end;
		int d;
		int rep;
		r.cycle_done = 1'b0;
		r.event_res = cspd_pkg::EV_NONE;
		r.timer_period = cspd_pkg::TP_KEEP;
		if (k) begin
			wait_left = '0;
			check_left = '0;
			check_pass = 1'b0;
			calib_left = 8'(NCAL);
			base_acc = '0;
			run_min = cspd_pkg::MIN_RESET;
			slot = '0;
			loaded = '0;
			calib_state = CAL_RUNNING;
			short_mode = 1'b0;
		end else begin
			if (s < run_min)
				run_min = s;
			if (int'(s) < int'(base_acc) - int'(cfg_shadow.load_margin))
				loaded = loaded + 8'd1;
			cycle_end = (int'(slot) + 1 >= SPC);
			if (!cycle_end) begin
				if (slot == 8'd0)
					r.timer_period = cspd_pkg::TP_MINOR;
				slot = slot + 8'd1;
			end else begin
				r.cycle_done = 1'b1;
				r.timer_period = short_mode ? cspd_pkg::TP_SHORT_MAJOR : cspd_pkg::TP_MAJOR;
				last_min = run_min;
				lvl_prev = lvl_now;
				lvl_now = scaled_level(longint'(base_acc) - longint'(last_min));
				abs_lvl = scaled_level(longint'(cfg_shadow.zero_reference) - longint'(last_min));
				if (calib_state == CAL_RUNNING) begin
					if (calib_left == 8'd0) begin
						calib_state = CAL_DONE;
						base_acc = BW'(int'(base_acc) / NCAL);
						wait_left = (cfg_shadow.wait_cycles == 8'd0) ? 8'd1 :
							cfg_shadow.wait_cycles;
						r.event_res = cspd_pkg::EV_CALIB_DONE;
					end else begin
						calib_left = calib_left - 8'd1;
						base_acc = base_acc + BW'(run_min);
					end
				end else if (wait_left != 8'd0) begin
					wait_left = wait_left - 8'd1;
					if (wait_left == 8'd0) begin
						calib_state = CAL_NONE;
						r.event_res = cspd_pkg::EV_CHECK_FAIL;
					end else if (loaded > cfg_shadow.limit_count) begin
						check_left = (cfg_shadow.check_cycles == 8'd0) ? 8'd1 :
							cfg_shadow.check_cycles;
						wait_left = '0;
						check_pass = 1'b1;
						r.event_res = cspd_pkg::EV_WAIT_OK;
						short_mode = 1'b1;
					end
				end else if (check_left != 8'd0) begin
					check_left = check_left - 8'd1;
					if (loaded <= cfg_shadow.limit_count)
						check_pass = 1'b0;
					if (check_left == 8'd0) begin
						short_mode = 1'b0;
						if (check_pass) begin
							r.event_res = cspd_pkg::EV_CHECK_OK;
						end else begin
							calib_state = CAL_NONE;
							r.event_res = cspd_pkg::EV_CHECK_FAIL;
						end
					end
				end else if (loaded > cfg_shadow.limit_count && !powered) begin
					powered = 1'b1;
					r.event_res = cspd_pkg::EV_POWER_ON;
				end else if (powered) begin
					d = int'(lvl_now) - int'(lvl_prev);
					if (loaded < cfg_shadow.limit_count) begin
						powered = 1'b0;
						r.event_res = cspd_pkg::EV_POWER_OFF;
					end else if (d >= 2 || d <= -2) begin
						r.event_res = cspd_pkg::EV_LEVEL_CHG;
					end
				end
				run_min = cspd_pkg::MIN_RESET;
				slot = '0;
				loaded = '0;
			end
		end
		rep = int'(lvl_now) + int'(powered);
		if (rep > int'(cfg_shadow.max_level))
			rep = int'(cfg_shadow.max_level);
		r.cycle_minimum = last_min;
		r.current_level = lvl_now;
		r.reported_level = rep[7:0];
		r.over_current = (int'(abs_lvl) >= int'(cfg_shadow.overcurrent_level));
		return r;
	endfunction

	function automatic cspd_pkg::cfg_t pick_config(input int mode);
		cspd_pkg::cfg_t c;
		case (mode)
			0: c = '0;
			1: c = '1;
			default: begin
				c.load_margin = 14'($urandom_range(50, 600));
				c.limit_count = 8'($urandom_range(0, 5));
				c.wait_cycles = 8'($urandom_range(0, 5));
				c.check_cycles = 8'($urandom_range(0, 5));
				c.level_scale = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(256, 6000));
				c.zero_reference = 14'($urandom_range(0, 16383));
				c.overcurrent_level = 7'($urandom_range(0, 127));
				c.max_level = 7'($urandom_range(0, 127));
			end
		endcase
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic program_config(input cspd_pkg::cfg_t c);
		write_reg(cspd_pkg::REG_LOAD_MARGIN, CFG_DW'(c.load_margin));
		write_reg(cspd_pkg::REG_LIMIT_COUNT, CFG_DW'(c.limit_count));
		write_reg(cspd_pkg::REG_WAIT_CYCLES, CFG_DW'(c.wait_cycles));
		write_reg(cspd_pkg::REG_CHECK_CYCLES, CFG_DW'(c.check_cycles));
		write_reg(cspd_pkg::REG_LEVEL_SCALE, CFG_DW'(c.level_scale));
		write_reg(cspd_pkg::REG_ZERO_REFERENCE, CFG_DW'(c.zero_reference));
		write_reg(cspd_pkg::REG_OVERCURRENT, CFG_DW'(c.overcurrent_level));
		write_reg(cspd_pkg::REG_MAX_LEVEL, CFG_DW'(c.max_level));
		cfg_wr_en <= 1'b0;
		cfg_shadow = c;
	endtask

	task automatic push_req(input logic k, input int v);
		req_t r;
		r.kind = k;
		r.sample = (v < 0) ? '0 : (v > 16383) ? cspd_pkg::MIN_RESET : v[SW-1:0];
		pend_q.push_back(r);
		queued++;
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || in_valid || exp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// calibrate on a quiet floor, then a run of loaded and quiet cycles
	task automatic build_session();
		int floor_val;
		int spread;
		int depth;
		int load_n;
		int left;
		int lim;
		int ncyc;
		floor_val = $urandom_range(2500, 16000);
		spread = $urandom_range(0, 40);
		ncyc = $urandom_range(4, 16);
		lim = int'(cfg_shadow.limit_count);
		push_req(1'b1, $urandom_range(0, 16383));
		for (int cyc = 0; cyc < NCAL + 1 + ncyc; cyc++) begin
			load_n = 0;
			if (cyc > NCAL) begin
				if ($urandom_range(0, 4) < 3)
					load_n = (lim >= SPC) ? SPC : $urandom_range(lim + 1, SPC);
				else
					load_n = $urandom_range(0, (lim >= SPC) ? SPC : lim);
			end
			depth = $urandom_range(0, 2500);
			left = load_n;
			for (int i = 0; i < SPC; i++) begin
				if ($urandom_range(0, 150) == 0)
					push_req(1'b1, $urandom_range(0, 16383));
				if (left > 0 && $urandom_range(1, SPC - i) <= left) begin
					left--;
					push_req(1'b0, floor_val - int'(cfg_shadow.load_margin) - 1 -
						$urandom_range(0, depth));
				end else begin
					push_req(1'b0, floor_val + $urandom_range(0, spread));
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				exp_q.push_back(detector_step(kind, sample));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					nxt = pend_q.pop_front();
					in_valid <= 1'b1;
					kind <= nxt.kind;
					sample <= nxt.sample;
					gap_left = in_fast ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_q.size() == 0) begin
					$display("%0t: result with no request pending, event %0d", $time, event_res);
					fail_count++;
				end else begin
					want = exp_q.pop_front();
					if (cycle_done !== want.cycle_done) begin
						$display("%0t: cycle_done expected %0d, got %0d", $time,
							want.cycle_done, cycle_done);
						fail_count++;
					end
					if (event_res !== want.event_res) begin
						$display("%0t: event_res expected %0d, got %0d", $time,
							want.event_res, event_res);
						fail_count++;
					end
					if (timer_period !== want.timer_period) begin
						$display("%0t: timer_period expected %0d, got %0d", $time,
							want.timer_period, timer_period);
						fail_count++;
					end
					if (cycle_minimum !== want.cycle_minimum) begin
						$display("%0t: cycle_minimum expected %0d, got %0d", $time,
							want.cycle_minimum, cycle_minimum);
						fail_count++;
					end
					if (current_level !== want.current_level) begin
						$display("%0t: current_level expected %0d, got %0d", $time,
							$signed(want.current_level), current_level);
						fail_count++;
					end
					if (reported_level !== want.reported_level) begin
						$display("%0t: reported_level expected %0d, got %0d", $time,
							$signed(want.reported_level), reported_level);
						fail_count++;
					end
					if (over_current !== want.over_current) begin
						$display("%0t: over_current expected %0d, got %0d", $time,
							want.over_current, over_current);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = out_fast ? 0 : pick_gap();
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_current_sensor_power_detector_top: done, errors");
		$finish;
	end

	initial begin
		cspd_pkg::cfg_t dir_cfg;
		int mode;
		cfg_shadow = '{load_margin: '0, limit_count: '0, wait_cycles: 8'd1,
			check_cycles: 8'd1, level_scale: '0, zero_reference: cspd_pkg::ZERO_REF_RESET,
			overcurrent_level: 7'd127, max_level: 7'd127};
		calib_state = CAL_NONE;
		calib_left = '0;
		base_acc = '0;
		wait_left = '0;
		check_left = '0;
		check_pass = 1'b0;
		slot = '0;
		loaded = '0;
		run_min = cspd_pkg::MIN_RESET;
		last_min = cspd_pkg::MIN_RESET;
		lvl_now = '0;
		lvl_prev = '0;
		abs_lvl = '0;
		powered = 1'b0;
		short_mode = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// register defaults: field extremes, start mid-cycle, one full cycle
		push_req(1'b0, 0);
		push_req(1'b0, 16383);
		push_req(1'b0, 1);
		push_req(1'b0, 8192);
		push_req(1'b0, 'h2AAA);
		push_req(1'b0, 'h1555);
		push_req(1'b1, 16383);
		push_req(1'b0, 16383);
		push_req(1'b0, 0);
		push_req(1'b0, 'h2AAA);
		push_req(1'b0, 'h1555);
		push_req(1'b0, 9000);
		push_req(1'b0, 16383);
		push_req(1'b0, 5);
		push_req(1'b0, 16382);
		drain();

		// saturating scale, zero wait/check counts, zero ceiling
		dir_cfg = '0;
		dir_cfg.load_margin = 14'h3FFF;
		dir_cfg.level_scale = 16'hFFFF;
		dir_cfg.zero_reference = 14'h3FFF;
		program_config(dir_cfg);
		repeat (SPC) push_req(1'b0, 0);
		drain();

		while (queued < ITEM_TARGET) begin
			mode = $urandom_range(0, 9);
			program_config(pick_config(mode));
			in_fast = ($urandom_range(0, 3) == 0);
			out_fast = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(20, 60))
					push_req($urandom_range(0, 15) == 0, $urandom_range(0, 16383));
			end else begin
				build_session();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_current_sensor_power_detector_top: done, clean");
		else
			$display("tb_current_sensor_power_detector_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/cspd_pkg.sv
design/cspd_cfg.sv
design/cspd_scale.sv
design/cspd_core.sv
design/current_sensor_power_detector_top.sv
dv/tb_current_sensor_power_detector_top.sv
